// File: rtl/sls_pkg.sv
`timescale 1ns / 1ps

package sls_pkg;

  typedef enum logic [1:0] {
    FN_CTRL = 2'd0,
    FN_TICK = 2'd1,
    FN_DRST = 2'd2,
    FN_DATA = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  localparam logic [7:0] SC_MASK   = 8'h81;
  localparam logic [7:0] SC_START  = 8'h80;
  localparam logic [7:0] SC_MASTER = 8'h01;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [3:0] NBITS     = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] control_bits;
    logic       active;
    logic       have_pb;
    logic       sent;
    logic [7:0] partner_byte;
    logic [3:0] bits_shifted;
    logic [3:0] edge_count;
  } port_state_t;

  typedef struct packed {
    logic tx_valid;
    logic rx_taken;
    logic flush;
    logic shift;
  } step_flags_t;

endpackage

// File: rtl/sls_step.sv
`timescale 1ns / 1ps

module sls_step import sls_pkg::*; (
  input  port_state_t cur,
  input  func_t       func,
  input  logic [7:0]  data,
  input  logic        div_old_bit,
  input  logic        div_new_bit,
  input  logic        link_connected,
  input  logic        link_rx_valid,
  input  logic [7:0]  link_rx_byte,
  output port_state_t nxt,
  output step_flags_t flags
);

  logic [7:0] sc;
  logic       fall;
  logic       run_m;
  logic       run_s;

  always_comb begin
    nxt   = cur;
    flags = '0;
    sc    = data & SC_MASK;
    fall  = (func == FN_TICK) ? (div_old_bit & ~div_new_bit) : div_old_bit;
    run_m = cur.active && ((cur.control_bits & SC_MASTER) != 8'h00) &&
            (func == FN_TICK || func == FN_DRST);
    run_s = cur.active && ((cur.control_bits & SC_MASTER) == 8'h00) &&
            (func == FN_TICK);
    case (func)
      FN_CTRL: begin
        if (!(cur.active && sc == cur.control_bits && (sc & SC_START) != 8'h00)) begin
          nxt.control_bits = sc;
          if ((sc & SC_START) != 8'h00) begin
            nxt.active       = 1'b1;
            nxt.have_pb      = 1'b0;
            nxt.bits_shifted = '0;
            nxt.sent         = 1'b0;
            nxt.partner_byte = FILL_BYTE;
            nxt.edge_count   = '0;
          end else begin
            nxt.active = 1'b0;
          end
          if (cur.active && cur.control_bits != sc) begin
            flags.flush = 1'b1;
            nxt.have_pb = 1'b0;
          end
        end
      end
      FN_DATA: begin
        nxt.data_byte = data;
      end
      default: begin
        if (run_m || run_s) begin
          if (fall && cur.edge_count < NBITS) begin
            nxt.edge_count = cur.edge_count + 4'd1;
          end
        end
        if (run_m) begin
          if (!cur.sent) begin
            flags.tx_valid = link_connected;
            nxt.sent       = 1'b1;
          end
          if (!cur.have_pb) begin
            if (!link_connected) begin
              nxt.partner_byte = FILL_BYTE;
              nxt.have_pb      = 1'b1;
            end else if (link_rx_valid) begin
              nxt.partner_byte = link_rx_byte;
              nxt.have_pb      = 1'b1;
              flags.rx_taken   = 1'b1;
            end
          end
          flags.shift = nxt.have_pb && fall;
        end else if (run_s) begin
          if (!cur.have_pb) begin
            if (link_rx_valid) begin
              nxt.partner_byte = link_rx_byte;
              nxt.have_pb      = 1'b1;
              nxt.bits_shifted = '0;
              flags.rx_taken   = 1'b1;
              flags.tx_valid   = 1'b1;
              flags.shift      = fall;
            end
          end else begin
            flags.shift = fall;
          end
        end
      end
    endcase
  end

endmodule

// File: rtl/sls_shift.sv
`timescale 1ns / 1ps

module sls_shift import sls_pkg::*; (
  input  port_state_t cur,
  output port_state_t nxt,
  output logic        more,
  output logic        done
);

  logic [2:0] sel;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    sel  = 3'd7 - cur.bits_shifted[2:0];
    if (cur.bits_shifted < NBITS) begin
      nxt.bits_shifted = cur.bits_shifted + 4'd1;
      nxt.data_byte    = {cur.data_byte[6:0], cur.partner_byte[sel]};
    end
    more = (nxt.edge_count > nxt.bits_shifted) && (nxt.bits_shifted < NBITS);
    if (!more && nxt.bits_shifted >= NBITS) begin
      nxt.have_pb      = 1'b0;
      nxt.active       = 1'b0;
      nxt.control_bits = cur.control_bits & ~SC_START;
      done             = 1'b1;
    end
  end

endmodule

// File: rtl/serial_link_shift_port_top.sv
`timescale 1ns / 1ps

// Channel  Handshake              Fields
// in       in_valid / in_ready    func, data, div_old_bit, div_new_bit,
//                                 link_connected, link_rx_valid, link_rx_byte
// out      out_valid / out_ready  tx_valid, tx_byte, rx_taken, flush_link,
//                                 transfer_done, data_reg, control_reg
//
// A word passes through IDLE and then EXEC, where the one-bit shift unit shifts at most
// one bit per pass; a catch-up stays in EXEC for each further bit, up to eight in all.
// A new word is taken while the previous result still waits in the output register.
// A stalled output holds the last cycle of the current word until the register frees.
// Reset clears the FSM and port state, loads the partner byte with 0xFF and empties the output.

module serial_link_shift_port_top import sls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data,
  input  logic       div_old_bit,
  input  logic       div_new_bit,
  input  logic       link_connected,
  input  logic       link_rx_valid,
  input  logic [7:0] link_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       rx_taken,
  output logic       flush_link,
  output logic       transfer_done,
  output logic [7:0] data_reg,
  output logic [7:0] control_reg
);

  state_t      state, state_next;
  port_state_t st, st_next;
  port_state_t step_nxt, sh_nxt;
  step_flags_t step_flags, fl, fl_next;
  logic        pend, pend_next;
  logic        done_r, done_next;
  logic [7:0]  tx_hold, tx_next;
  logic        sh_more, sh_done;
  logic        last, emit;

  sls_step u_step (
    .cur            (st),
    .func           (func_t'(func)),
    .data           (data),
    .div_old_bit    (div_old_bit),
    .div_new_bit    (div_new_bit),
    .link_connected (link_connected),
    .link_rx_valid  (link_rx_valid),
    .link_rx_byte   (link_rx_byte),
    .nxt            (step_nxt),
    .flags          (step_flags)
  );

  sls_shift u_shift (
    .cur  (st),
    .nxt  (sh_nxt),
    .more (sh_more),
    .done (sh_done)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend   <= 1'b0;
      done_r <= 1'b0;
      fl     <= '0;
      st     <= '{data_byte: 8'h00, control_bits: 8'h00, active: 1'b0, have_pb: 1'b0,
                  sent: 1'b0, partner_byte: FILL_BYTE, bits_shifted: 4'd0,
                  edge_count: 4'd0};
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      done_r <= done_next;
      fl     <= fl_next;
      st     <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    tx_hold <= tx_next;
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    pend_next  = pend;
    done_next  = done_r;
    fl_next    = fl;
    tx_next    = tx_hold;
    last       = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          st_next    = step_nxt;
          fl_next    = step_flags;
          pend_next  = step_flags.shift;
          done_next  = 1'b0;
          tx_next    = st.data_byte;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pend) begin
          st_next = sh_nxt;
          if (!sh_more) begin
            pend_next = 1'b0;
            done_next = sh_done;
          end
        end
        last = !pend || !sh_more;
        if (last && (!out_valid || out_ready)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_valid      <= fl_next.tx_valid;
      tx_byte       <= tx_next;
      rx_taken      <= fl_next.rx_taken;
      flush_link    <= fl_next.flush;
      transfer_done <= done_next;
      data_reg      <= st_next.data_byte;
      control_reg   <= st_next.control_bits;
    end
  end

`ifndef SYNTH
  a_pend_active: assert property (@(posedge clk) disable iff (rst)
    pend |-> (st.active && st.have_pb))
    else $error("shift pending without an active transfer holding a partner byte");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("shift pending while idle");

  a_done_clears_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && transfer_done) |-> !control_reg[7])
    else $error("transfer done reported with start bit still set");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (st.bits_shifted <= NBITS) && (st.edge_count <= NBITS))
    else $error("bit or edge count beyond eight");
`endif

endmodule

// File: tb/sv/tb_serial_link_shift_port_top.sv
`timescale 1ns / 1ps

module tb_serial_link_shift_port_top;
  import sls_pkg::*;

  localparam int TOTAL_WORDS = 1150;
  localparam int TAIL_WORDS  = 100;

  typedef struct {
    func_t      fn;
    logic [7:0] data;
    logic       div_old;
    logic       div_new;
    logic       conn;
    logic       rxv;
    logic [7:0] rxb;
    bit         drain;
  } port_word_t;

  typedef struct {
    logic       txv;
    logic [7:0] txb;
    logic       rxt;
    logic       flush;
    logic       done;
    logic [7:0] dreg;
    logic [7:0] creg;
  } port_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FN_TICK;
  logic [7:0] data = 8'h00;
  logic       div_old_bit = 1'b0;
  logic       div_new_bit = 1'b0;
  logic       link_connected = 1'b0;
  logic       link_rx_valid = 1'b0;
  logic [7:0] link_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_taken;
  logic       flush_link;
  logic       transfer_done;
  logic [7:0] data_reg;
  logic [7:0] control_reg;

  serial_link_shift_port_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .data           (data),
    .div_old_bit    (div_old_bit),
    .div_new_bit    (div_new_bit),
    .link_connected (link_connected),
    .link_rx_valid  (link_rx_valid),
    .link_rx_byte   (link_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .rx_taken       (rx_taken),
    .flush_link     (flush_link),
    .transfer_done  (transfer_done),
    .data_reg       (data_reg),
    .control_reg    (control_reg)
  );

  port_word_t   pending_words[$];
  port_result_t expected_results[$];
  port_word_t   word_on_bus;
  bit           word_held = 1'b0;
  bit           in_taken = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           words_queued = 0;
  int           words_accepted = 0;
  int           results_seen = 0;
  int           dones_seen = 0;
  int           flushes_seen = 0;
  int           catch_ups = 0;
  int           errors = 0;

  // Shadow copy of the port state.
  logic [7:0] sh_data = 8'h00;
  logic [7:0] sh_ctrl = 8'h00;
  logic       sh_active = 1'b0;
  logic       sh_have = 1'b0;
  logic       sh_sent = 1'b0;
  logic [7:0] sh_pbyte = FILL_BYTE;
  logic [3:0] sh_bits = 4'd0;
  logic [3:0] sh_edges = 4'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void shadow_shift(inout port_result_t r);
    int n;
    n = 0;
    do begin
      if (sh_bits < NBITS) begin
        sh_data = {sh_data[6:0], sh_pbyte[3'd7 - sh_bits[2:0]]};
        sh_bits++;
        n++;
      end
    end while (sh_edges > sh_bits && sh_bits < NBITS);
    if (n > 1) catch_ups++;
    if (sh_bits >= NBITS) begin
      sh_have = 1'b0;
      sh_active = 1'b0;
      sh_ctrl = sh_ctrl & ~SC_START;
      r.done = 1'b1;
    end
  endfunction

  function automatic void shadow_master(input logic fall, input port_word_t w,
                                        inout port_result_t r);
    if (!sh_sent) begin
      if (w.conn) r.txv = 1'b1;
      sh_sent = 1'b1;
    end
    if (fall && sh_edges < NBITS) sh_edges++;
    if (!sh_have) begin
      if (!w.conn) begin
        sh_pbyte = FILL_BYTE;
        sh_have = 1'b1;
      end else if (w.rxv) begin
        sh_pbyte = w.rxb;
        sh_have = 1'b1;
        r.rxt = 1'b1;
      end
    end
    if (sh_have && fall) shadow_shift(r);
  endfunction

  function automatic port_result_t predict_port_result(port_word_t w);
    port_result_t r;
    logic         fall;
    logic [7:0]   sc;
    logic         was;
    logic [7:0]   old;
    r = '{default: '0};
    r.txb = sh_data;
    case (w.fn)
      FN_CTRL: begin
        sc = w.data & SC_MASK;
        was = sh_active;
        old = sh_ctrl;
        if (!(was && sc == old && (sc & SC_START) != 0)) begin
          sh_ctrl = sc;
          if ((sc & SC_START) != 0) begin
            sh_active = 1'b1;
            sh_have = 1'b0;
            sh_bits = 4'd0;
            sh_sent = 1'b0;
            sh_pbyte = FILL_BYTE;
            sh_edges = 4'd0;
          end else begin
            sh_active = 1'b0;
          end
          if (was && old != sc) begin
            r.flush = 1'b1;
            sh_have = 1'b0;
          end
        end
      end
      FN_DATA: sh_data = w.data;
      FN_TICK: begin
        if (sh_active) begin
          fall = w.div_old & ~w.div_new;
          if ((sh_ctrl & SC_MASTER) != 0) begin
            shadow_master(fall, w, r);
          end else begin
            if (fall && sh_edges < NBITS) sh_edges++;
            if (!sh_have && w.rxv) begin
              sh_pbyte = w.rxb;
              sh_have = 1'b1;
              r.rxt = 1'b1;
              sh_bits = 4'd0;
              r.txv = 1'b1;
            end
            if (sh_have && fall) shadow_shift(r);
          end
        end
      end
      FN_DRST: begin
        if (sh_active && (sh_ctrl & SC_MASTER) != 0) shadow_master(w.div_old, w, r);
      end
    endcase
    r.dreg = sh_data;
    r.creg = sh_ctrl;
    return r;
  endfunction

  task automatic add_word(input func_t f, input logic [7:0] d, input logic o, input logic n,
                          input logic c, input logic v, input logic [7:0] b, input bit drain);
    port_word_t w;
    w = '{fn: f, data: d, div_old: o, div_new: n, conn: c, rxv: v, rxb: b, drain: drain};
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic add_transfer();
    logic       div;
    logic       conn;
    logic       nb;
    logic [7:0] ctl;
    int         ticks;
    div = 1'($urandom_range(0, 1));
    conn = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 2) == 0)
      add_word(FN_DATA, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom), 1'b0);
    ctl = 8'($urandom);
    ctl[7] = ($urandom_range(0, 9) != 0);
    add_word(FN_CTRL, ctl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
             ($urandom_range(0, 9) == 0));
    ticks = $urandom_range(6, 36);
    repeat (ticks) begin
      case ($urandom_range(0, 39))
        0, 1, 2: begin
          add_word(FN_DRST, 8'($urandom), div, 1'($urandom_range(0, 1)), conn,
                   ($urandom_range(0, 2) == 0), 8'($urandom), 1'b0);
          div = 1'b0;
        end
        3: add_word(func_t'(2'($urandom_range(0, 3))), 8'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom), 1'b0);
        4: add_word(FN_DATA, 8'($urandom), div, div, conn, 1'($urandom_range(0, 1)),
                    8'($urandom), 1'b0);
        5: begin
          if ($urandom_range(0, 1) == 0) ctl = ctl ^ (8'($urandom) & 8'h7E);
          else ctl = 8'($urandom);
          add_word(FN_CTRL, ctl, div, div, conn, 1'($urandom_range(0, 1)), 8'($urandom),
                   1'b0);
        end
        default: begin
          nb = 1'($urandom_range(0, 1));
          add_word(FN_TICK, 8'($urandom), div, nb, conn, ($urandom_range(0, 2) == 0),
                   8'($urandom), 1'b0);
          div = nb;
        end
      endcase
      if ($urandom_range(0, 29) == 0) conn = ~conn;
    end
  endtask

  function automatic bit quiet_phase();
    return ((words_accepted / 80) % 4 == 3) || (pending_words.size() < TAIL_WORDS);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin : drive_words
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        word_held = 1'b0;
        if (!quiet_phase() && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
      end
      if (!word_held) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && expected_results.size() > 0)) begin
          word_on_bus = pending_words.pop_front();
          func <= word_on_bus.fn;
          data <= word_on_bus.data;
          div_old_bit <= word_on_bus.div_old;
          div_new_bit <= word_on_bus.div_new;
          link_connected <= word_on_bus.conn;
          link_rx_valid <= word_on_bus.rxv;
          link_rx_byte <= word_on_bus.rxb;
          word_held = 1'b1;
        end
      end
    end
    in_valid <= word_held;
  end

  always @(negedge clk) begin : drive_ready
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!rst && !quiet_phase() && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_ports
    port_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_port_result(word_on_bus));
        in_taken = 1'b1;
        words_accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_valid", want.txv, tx_valid);
          check_field("tx_byte", want.txb, tx_byte);
          check_field("rx_taken", want.rxt, rx_taken);
          check_field("flush_link", want.flush, flush_link);
          check_field("transfer_done", want.done, transfer_done);
          check_field("data_reg", want.dreg, data_reg);
          check_field("control_reg", want.creg, control_reg);
          if (want.done) dones_seen++;
          if (want.flush) flushes_seen++;
        end
      end
    end
  end

  initial begin
    // Idle port: ticks and divider resets do nothing.
    add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h55, 1'b0);
    add_word(FN_DRST, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'hAA, 1'b0);
    add_word(FN_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0);
    add_word(FN_CTRL, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_DATA, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    // Master with no partner shifts in the fill byte; a repeated start is ignored.
    add_word(FN_CTRL, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    add_word(FN_CTRL, 8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_DRST, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    repeat (6) add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    // Connected master counts edges before the partner byte arrives, then catches up.
    add_word(FN_CTRL, 8'h81, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    repeat (3) add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h3C, 1'b0);
    // Mode change mid transfer flushes, and the slave catches up after its byte.
    add_word(FN_CTRL, 8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
    repeat (2) add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
    add_word(FN_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_word(FN_DRST, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h12, 1'b0);
    add_word(FN_CTRL, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    while (words_queued < TOTAL_WORDS) add_transfer();

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || word_held) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d words and %0d results: %0d transfers completed, %0d flushes.",
             words_accepted, results_seen, dones_seen, flushes_seen);
    $display("Multi-bit catch-ups predicted: %0d.", catch_ups);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
